/* sv/mint_pkg.sv */
// Shared types and constants for the motion intensity normalizer.
// No dependencies; every other file of the block refers to this package.

package mint_pkg;

    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int DECAY_FRAC_BITS_DEF = 16;
    localparam int TIME_W              = 32;
    localparam int DECAY_W             = 16;
    localparam int REL_W               = 8;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic               ENABLE_RESET = 1'b1;
    localparam logic [DECAY_W-1:0] DECAY_RESET  = 16'd64880;
    localparam logic [REL_W-1:0]   REL_MAX      = 8'd255;

    typedef enum logic [0:0] {
        REG_ENABLE       = 1'b0,
        REG_DECAY_FACTOR = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_JERK,
        DIV_SPIN,
        DIV_CHANGE
    } t_div_sel;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_PEAK,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_HI,
        ST_MUL_LO,
        ST_DECAY,
        ST_DONE,
        ST_BYPASS
    } t_state;

    typedef struct packed {
        logic     load;
        logic     sum;
        logic     peak;
        logic     div_start;
        t_div_sel div_sel;
        logic     div_store;
        logic     mul_hi;
        logic     mul_lo;
        logic     decay;
        logic     out_load;
        logic     out_zero;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_status;

endpackage

/* sv/mint_if.sv */
// Handshake channels for input samples and results of the normalizer.
// Depends on mint_pkg for default widths.

interface mint_in_if #(
    parameter int SAMPLE_BITS = mint_pkg::SAMPLE_BITS_DEF
);
    logic                               valid;
    logic                               ready;
    logic        [mint_pkg::TIME_W-1:0] timestamp_ms;
    logic signed [SAMPLE_BITS-1:0]      gyro_y;
    logic signed [SAMPLE_BITS-1:0]      gyro_z;
    logic signed [SAMPLE_BITS-1:0]      accel_x;
    logic signed [SAMPLE_BITS-1:0]      accel_y;
    logic signed [SAMPLE_BITS-1:0]      accel_z;

    modport source (output valid, timestamp_ms, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                    input ready);
    modport sink (input valid, timestamp_ms, gyro_y, gyro_z, accel_x, accel_y, accel_z,
                  output ready);
endinterface

interface mint_out_if #(
    parameter int SAMPLE_BITS = mint_pkg::SAMPLE_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         updated;
    logic [mint_pkg::TIME_W-1:0]  elapsed_ms;
    logic [SAMPLE_BITS:0]         spin_speed;
    logic [SAMPLE_BITS:0]         jerk_level;
    logic [mint_pkg::REL_W-1:0]   relative_jerk;
    logic [mint_pkg::REL_W-1:0]   relative_spin;
    logic [mint_pkg::REL_W-1:0]   relative_spin_change;

    modport source (output valid, updated, elapsed_ms, spin_speed, jerk_level, relative_jerk,
                    relative_spin, relative_spin_change, input ready);
    modport sink (input valid, updated, elapsed_ms, spin_speed, jerk_level, relative_jerk,
                  relative_spin, relative_spin_change, output ready);
endinterface

/* sv/motion_intensity_normalizer.sv */
// Motion intensity normalizer top level: configuration registers, sequencer and datapath.
// Depends on mint_pkg, mint_if, mint_ctrl, mint_dp and mint_div.
// A processed item's result is loaded after three divisions on the shared 8-step divider
// (a zero or full-scale case skips the steps) and the spin peak decay; a disabled item's zero
// result is loaded directly. A new item is taken only after the last result has been loaded.
// Synchronous active-low reset clears all running state and peaks and restores the registers.

module motion_intensity_normalizer #(
    parameter int SAMPLE_BITS     = mint_pkg::SAMPLE_BITS_DEF,
    parameter int DECAY_FRAC_BITS = mint_pkg::DECAY_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    mint_in_if.sink                             i_in,
    mint_out_if.source                          o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mint_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [mint_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [mint_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int DW = mint_pkg::APB_DATA_W;
    localparam int FW = mint_pkg::DECAY_W;

    logic                 r_enable;
    logic [FW-1:0]        r_decay;
    mint_pkg::t_reg_idx   w_idx;
    mint_pkg::t_dp_cmd    w_cmd;
    mint_pkg::t_dp_status w_status;

    assign w_idx  = mint_pkg::t_reg_idx'(paddr[2]);
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= mint_pkg::ENABLE_RESET;
            r_decay  <= mint_pkg::DECAY_RESET;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                mint_pkg::REG_ENABLE:       r_enable <= pwdata[0];
                mint_pkg::REG_DECAY_FACTOR: r_decay  <= pwdata[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            mint_pkg::REG_ENABLE:       prdata = {{(DW-1){1'b0}}, r_enable};
            mint_pkg::REG_DECAY_FACTOR: prdata = {{(DW-FW){1'b0}}, r_decay};
            default:                    prdata = '0;
        endcase
    end

    mint_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_enable   (r_enable),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    mint_dp #(
        .SAMPLE_BITS     (SAMPLE_BITS),
        .DECAY_FRAC_BITS (DECAY_FRAC_BITS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .o_status               (w_status),
        .i_decay                (r_decay),
        .i_timestamp_ms         (i_in.timestamp_ms),
        .i_gyro_y               (i_in.gyro_y),
        .i_gyro_z               (i_in.gyro_z),
        .i_accel_x              (i_in.accel_x),
        .i_accel_y              (i_in.accel_y),
        .i_accel_z              (i_in.accel_z),
        .o_valid                (o_out.valid),
        .i_ready                (o_out.ready),
        .o_updated              (o_out.updated),
        .o_elapsed_ms           (o_out.elapsed_ms),
        .o_spin_speed           (o_out.spin_speed),
        .o_jerk_level           (o_out.jerk_level),
        .o_relative_jerk        (o_out.relative_jerk),
        .o_relative_spin        (o_out.relative_spin),
        .o_relative_spin_change (o_out.relative_spin_change)
    );

endmodule

/* sv/mint_div.sv */
// Shared radix-2 divider giving floor(num * 255 / den) as an 8-bit value.
// Zero denominator gives 0 and num >= den gives 255. Depends on mint_pkg.

module mint_div #(
    parameter int DW = 33
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [DW-1:0]              i_num,
    input  logic [DW-1:0]              i_den,
    output logic                       o_done,
    output logic [mint_pkg::REL_W-1:0] o_quot
);

    localparam int RW = mint_pkg::REL_W;

    logic                 r_busy;
    logic                 r_done;
    logic [2:0]           r_cnt;
    logic [DW-1:0]        r_rem;
    logic [DW-1:0]        r_den;
    logic [RW-1:0]        r_low;
    logic [RW-1:0]        r_quot;

    logic [DW+RW-1:0]     w_prod;
    logic [DW:0]          w_trial;
    logic                 w_fit;
    logic [DW:0]          w_diff;

    assign w_prod  = {i_num, {RW{1'b0}}} - {{RW{1'b0}}, i_num};
    assign w_trial = {r_rem, r_low[RW-1]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0 || i_num >= i_den) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= 3'd7;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_den;
            r_rem <= w_prod[DW+RW-1:RW];
            r_low <= w_prod[RW-1:0];
            if (i_den == '0) begin
                r_quot <= '0;
            end else if (i_num >= i_den) begin
                r_quot <= mint_pkg::REL_MAX;
            end else begin
                r_quot <= '0;
            end
        end else if (r_busy) begin
            r_rem  <= w_fit ? w_diff[DW-1:0] : w_trial[DW-1:0];
            r_low  <= {r_low[RW-2:0], 1'b0};
            r_quot <= {r_quot[RW-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("partial remainder reached the divisor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("done held for more than one cycle");
`endif

endmodule

/* sv/mint_dp.sv */
// Datapath of the normalizer: sample capture, running state, peaks, decay
// multiplier, the shared divider and the result register. Depends on mint_pkg, mint_div.

module mint_dp #(
    parameter int SAMPLE_BITS     = mint_pkg::SAMPLE_BITS_DEF,
    parameter int DECAY_FRAC_BITS = mint_pkg::DECAY_FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mint_pkg::t_dp_cmd                 i_cmd,
    output mint_pkg::t_dp_status              o_status,
    input  logic [mint_pkg::DECAY_W-1:0]      i_decay,
    input  logic [mint_pkg::TIME_W-1:0]       i_timestamp_ms,
    input  logic signed [SAMPLE_BITS-1:0]     i_gyro_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_gyro_z,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_x,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_y,
    input  logic signed [SAMPLE_BITS-1:0]     i_accel_z,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_updated,
    output logic [mint_pkg::TIME_W-1:0]       o_elapsed_ms,
    output logic [SAMPLE_BITS:0]              o_spin_speed,
    output logic [SAMPLE_BITS:0]              o_jerk_level,
    output logic [mint_pkg::REL_W-1:0]        o_relative_jerk,
    output logic [mint_pkg::REL_W-1:0]        o_relative_spin,
    output logic [mint_pkg::REL_W-1:0]        o_relative_spin_change
);

    localparam int S   = SAMPLE_BITS;
    localparam int F   = DECAY_FRAC_BITS;
    localparam int VW  = S + 1;
    localparam int PW  = VW + F;
    localparam int AW  = (VW > F) ? VW : F;
    localparam int TW  = mint_pkg::TIME_W;
    localparam int DFW = mint_pkg::DECAY_W;
    localparam int RW  = mint_pkg::REL_W;

    function automatic logic [S-1:0] f_mag(input logic [S-1:0] v);
        f_mag = v[S-1] ? (~v + {{(S-1){1'b0}}, 1'b1}) : v;
    endfunction

    function automatic logic [VW-1:0] f_absdiff(input logic [VW-1:0] a, input logic [VW-1:0] b);
        f_absdiff = (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [TW-1:0]  r_ts;
    logic [S-1:0]   r_gy;
    logic [S-1:0]   r_gz;
    logic [S-1:0]   r_ax;
    logic [S-1:0]   r_ay;
    logic [S-1:0]   r_az;

    logic [TW-1:0]  r_last_time;
    logic [VW-1:0]  r_last_accel;
    logic [VW-1:0]  r_last_spin;
    logic [VW-1:0]  r_peak_jerk;
    logic [VW-1:0]  r_peak_change;
    logic [PW-1:0]  r_peak_spin;

    logic [TW-1:0]  r_elapsed;
    logic [VW-1:0]  r_spin;
    logic [VW-1:0]  r_accel;
    logic [VW-1:0]  r_jerk;
    logic [VW-1:0]  r_change;
    logic [RW-1:0]  r_rel_jerk;
    logic [RW-1:0]  r_rel_spin;
    logic [RW-1:0]  r_rel_change;
    logic [PW-1:0]  r_prod_hi;
    logic [DFW-1:0] r_prod_lo;

    logic           r_out_valid;
    logic           r_out_updated;
    logic [TW-1:0]  r_out_elapsed;
    logic [VW-1:0]  r_out_spin;
    logic [VW-1:0]  r_out_jerk;
    logic [RW-1:0]  r_out_rel_jerk;
    logic [RW-1:0]  r_out_rel_spin;
    logic [RW-1:0]  r_out_rel_change;

    logic [VW-1:0]     w_jerk;
    logic [VW-1:0]     w_change;
    logic [PW-1:0]     w_spin_fx;
    logic [AW-1:0]     w_mul_a;
    logic [AW+DFW-1:0] w_mul;
    logic [PW-1:0]     w_div_num;
    logic [PW-1:0]     w_div_den;
    logic              w_div_done;
    logic [RW-1:0]     w_div_quot;

    assign w_jerk    = f_absdiff(r_accel, r_last_accel);
    assign w_change  = f_absdiff(r_spin, r_last_spin);
    assign w_spin_fx = {r_spin, {F{1'b0}}};
    assign w_mul_a   = i_cmd.mul_lo ? AW'(r_peak_spin[F-1:0]) : AW'(r_peak_spin[PW-1:F]);
    assign w_mul     = w_mul_a * i_decay;

    always_comb begin
        case (i_cmd.div_sel)
            mint_pkg::DIV_JERK: begin
                w_div_num = PW'(r_jerk);
                w_div_den = PW'(r_peak_jerk);
            end
            mint_pkg::DIV_SPIN: begin
                w_div_num = w_spin_fx;
                w_div_den = r_peak_spin;
            end
            mint_pkg::DIV_CHANGE: begin
                w_div_num = PW'(r_change);
                w_div_den = PW'(r_peak_change);
            end
            default: begin
                w_div_num = '0;
                w_div_den = '0;
            end
        endcase
    end

    mint_div #(
        .DW (PW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ts <= i_timestamp_ms;
            r_gy <= i_gyro_y;
            r_gz <= i_gyro_z;
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
        end
        if (i_cmd.sum) begin
            r_elapsed <= r_ts - r_last_time;
            r_spin    <= {1'b0, f_mag(r_gy)} + {1'b0, f_mag(r_gz)};
            r_accel   <= {1'b0, f_mag(r_ax)} + {1'b0, f_mag(r_ay)} + {1'b0, f_mag(r_az)};
        end
        if (i_cmd.peak) begin
            r_jerk   <= w_jerk;
            r_change <= w_change;
        end
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                mint_pkg::DIV_JERK:   r_rel_jerk   <= w_div_quot;
                mint_pkg::DIV_SPIN:   r_rel_spin   <= w_div_quot;
                mint_pkg::DIV_CHANGE: r_rel_change <= w_div_quot;
                default: begin
                end
            endcase
        end
        if (i_cmd.mul_hi) begin
            r_prod_hi <= PW'(w_mul);
        end
        if (i_cmd.mul_lo) begin
            r_prod_lo <= DFW'(w_mul >> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time   <= '0;
            r_last_accel  <= '0;
            r_last_spin   <= '0;
            r_peak_jerk   <= '0;
            r_peak_change <= '0;
            r_peak_spin   <= '0;
        end else begin
            if (i_cmd.sum) begin
                r_last_time <= r_ts;
            end
            if (i_cmd.peak) begin
                r_last_accel <= r_accel;
                r_last_spin  <= r_spin;
                if (w_jerk > r_peak_jerk) begin
                    r_peak_jerk <= w_jerk;
                end
                if (w_change > r_peak_change) begin
                    r_peak_change <= w_change;
                end
                if (w_spin_fx > r_peak_spin) begin
                    r_peak_spin <= w_spin_fx;
                end
            end
            if (i_cmd.decay) begin
                r_peak_spin <= r_prod_hi + PW'(r_prod_lo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_zero) begin
                r_out_updated    <= 1'b0;
                r_out_elapsed    <= '0;
                r_out_spin       <= '0;
                r_out_jerk       <= '0;
                r_out_rel_jerk   <= '0;
                r_out_rel_spin   <= '0;
                r_out_rel_change <= '0;
            end else begin
                r_out_updated    <= 1'b1;
                r_out_elapsed    <= r_elapsed;
                r_out_spin       <= r_spin;
                r_out_jerk       <= r_jerk;
                r_out_rel_jerk   <= r_rel_jerk;
                r_out_rel_spin   <= r_rel_spin;
                r_out_rel_change <= r_rel_change;
            end
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_ready;

    assign o_valid                = r_out_valid;
    assign o_updated              = r_out_updated;
    assign o_elapsed_ms           = r_out_elapsed;
    assign o_spin_speed           = r_out_spin;
    assign o_jerk_level           = r_out_jerk;
    assign o_relative_jerk        = r_out_rel_jerk;
    assign o_relative_spin        = r_out_rel_spin;
    assign o_relative_spin_change = r_out_rel_change;

endmodule

/* sv/mint_ctrl.sv */
// Sequencer of the normalizer: steps one item through sums, peak update,
// three divisions, spin peak decay and result hand-off, or a disabled item to a zeroed result. Depends on mint_pkg.

module mint_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_enable,
    input  mint_pkg::t_dp_status i_status,
    output mint_pkg::t_dp_cmd    o_cmd
);

    mint_pkg::t_state   r_state;
    mint_pkg::t_state   n_state;
    mint_pkg::t_div_sel r_div_sel;
    mint_pkg::t_div_sel n_div_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mint_pkg::ST_IDLE;
            r_div_sel <= mint_pkg::DIV_JERK;
        end else begin
            r_state   <= n_state;
            r_div_sel <= n_div_sel;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_div_sel = r_div_sel;
        case (r_state)
            mint_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_enable ? mint_pkg::ST_SUM : mint_pkg::ST_BYPASS;
                end
            end
            mint_pkg::ST_SUM: begin
                n_state = mint_pkg::ST_PEAK;
            end
            mint_pkg::ST_PEAK: begin
                n_state   = mint_pkg::ST_DIV_START;
                n_div_sel = mint_pkg::DIV_JERK;
            end
            mint_pkg::ST_DIV_START: begin
                n_state = mint_pkg::ST_DIV_WAIT;
            end
            mint_pkg::ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    case (r_div_sel)
                        mint_pkg::DIV_JERK: begin
                            n_div_sel = mint_pkg::DIV_SPIN;
                            n_state   = mint_pkg::ST_DIV_START;
                        end
                        mint_pkg::DIV_SPIN: begin
                            n_div_sel = mint_pkg::DIV_CHANGE;
                            n_state   = mint_pkg::ST_DIV_START;
                        end
                        default: begin
                            n_state = mint_pkg::ST_MUL_HI;
                        end
                    endcase
                end
            end
            mint_pkg::ST_MUL_HI: begin
                n_state = mint_pkg::ST_MUL_LO;
            end
            mint_pkg::ST_MUL_LO: begin
                n_state = mint_pkg::ST_DECAY;
            end
            mint_pkg::ST_DECAY: begin
                n_state = mint_pkg::ST_DONE;
            end
            mint_pkg::ST_DONE, mint_pkg::ST_BYPASS: begin
                if (i_status.out_free) begin
                    n_state = mint_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mint_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.div_sel = r_div_sel;
        o_in_ready    = 1'b0;
        case (r_state)
            mint_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            mint_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
            end
            mint_pkg::ST_PEAK: begin
                o_cmd.peak = 1'b1;
            end
            mint_pkg::ST_DIV_START: begin
                o_cmd.div_start = 1'b1;
            end
            mint_pkg::ST_DIV_WAIT: begin
                o_cmd.div_store = i_status.div_done;
            end
            mint_pkg::ST_MUL_HI: begin
                o_cmd.mul_hi = 1'b1;
            end
            mint_pkg::ST_MUL_LO: begin
                o_cmd.mul_lo = 1'b1;
            end
            mint_pkg::ST_DECAY: begin
                o_cmd.decay = 1'b1;
            end
            mint_pkg::ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            mint_pkg::ST_BYPASS: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.out_zero = 1'b1;
            end
            default: begin
            end
        endcase
    end

endmodule
